### hdl/lppd_pkg.sv
`timescale 1ns / 1ps

package lppd_pkg;

    localparam logic [7:0] START_BYTE_RESET = 8'hAA;

    typedef enum logic [4:0] {
        PH_READY   = 5'b00001,
        PH_ID      = 5'b00010,
        PH_TYPE    = 5'b00100,
        PH_LENGTH  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [31:0] node_id;
        logic [7:0]  msg_type;
        logic [15:0] payload_length;
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

endpackage

### hdl/length_prefixed_packet_deframer_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_byte_in
// output    out        o_out_valid / i_out_stall  o_node_id, o_msg_type, o_payload_length,
//                                                 o_has_byte, o_data_byte, o_last
// config    in         i_cfg_wr_en                i_cfg_wr_data
//
// One byte is accepted per cycle unless stalled; any result appears in the next cycle.
// Header state and the result register update in the same cycle, so the only pause comes
// from the output register being full and stalled, which stalls the input.
// Synchronous active-low reset returns to hunting for the start byte and empties the output.
// The start byte register resets to 0xAA.

module length_prefixed_packet_deframer_top
    import lppd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_node_id,
    output logic [7:0]  o_msg_type,
    output logic [15:0] o_payload_length,
    output logic        o_has_byte,
    output logic [7:0]  o_data_byte,
    output logic        o_last
);

    logic [7:0]  r_start_byte;
    t_phase      r_phase, n_phase;
    logic        r_field_index, n_field_index;
    logic [1:0]  r_id_count, n_id_count;
    logic [31:0] r_id_accum, n_id_accum;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;
    logic        r_out_valid;
    t_result     r_out, n_out;
    logic        n_emit;
    logic        in_accept;
    logic [15:0] count_inc;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign count_inc  = r_count + 16'd1;

    always_comb begin
        n_phase       = r_phase;
        n_field_index = r_field_index;
        n_id_count    = r_id_count;
        n_id_accum    = r_id_accum;
        n_type        = r_type;
        n_length      = r_length;
        n_count       = r_count;
        n_emit        = 1'b0;
        n_out         = '0;
        unique case (r_phase)
            PH_READY: begin
                if (i_byte_in == r_start_byte) begin
                    n_phase       = PH_ID;
                    n_field_index = 1'b0;
                    n_id_count    = 2'd0;
                    n_id_accum    = '0;
                    n_type        = '0;
                    n_length      = '0;
                    n_count       = '0;
                end
            end
            PH_ID: begin
                n_id_accum = {r_id_accum[23:0], i_byte_in};
                n_id_count = r_id_count + 2'd1;
                if (r_id_count == 2'd3) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type        = i_byte_in;
                n_field_index = 1'b0;
                n_phase       = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (!r_field_index) begin
                    n_length      = {i_byte_in, 8'h00};
                    n_field_index = 1'b1;
                end else begin
                    n_length      = {r_length[15:8], i_byte_in};
                    n_field_index = 1'b0;
                    n_count       = '0;
                    if ({r_length[15:8], i_byte_in} == 16'd0) begin
                        n_phase = PH_READY;
                        n_emit  = 1'b1;
                        n_out.has_byte = 1'b0;
                        n_out.last     = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_count        = count_inc;
                n_emit         = 1'b1;
                n_out.has_byte = 1'b1;
                n_out.data_byte = i_byte_in;
                if (count_inc == r_length) begin
                    n_phase    = PH_READY;
                    n_out.last = 1'b1;
                end
            end
            default: begin
                n_phase       = PH_READY;
                n_field_index = 1'b0;
            end
        endcase
        n_out.node_id        = n_id_accum;
        n_out.msg_type       = n_type;
        n_out.payload_length = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RESET;
            r_phase       <= PH_READY;
            r_field_index <= 1'b0;
            r_id_count    <= 2'd0;
            r_id_accum    <= '0;
            r_type        <= '0;
            r_length      <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_byte <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_phase       <= n_phase;
                r_field_index <= n_field_index;
                r_id_count    <= n_id_count;
                r_id_accum    <= n_id_accum;
                r_type        <= n_type;
                r_length      <= n_length;
                r_count       <= n_count;
            end
            if (!o_in_stall) begin
                r_out_valid <= in_accept & n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_node_id        = r_out.node_id;
    assign o_msg_type       = r_out.msg_type;
    assign o_payload_length = r_out.payload_length;
    assign o_has_byte       = r_out.has_byte;
    assign o_data_byte      = r_out.data_byte;
    assign o_last           = r_out.last;

endmodule

### hdl/lppd_checker.sv
`timescale 1ns / 1ps

module lppd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_node_id,
    input logic [7:0]  o_msg_type,
    input logic [15:0] o_payload_length,
    input logic        o_has_byte,
    input logic [7:0]  o_data_byte,
    input logic        o_last
);

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_node_id)
            && $stable(o_msg_type) && $stable(o_payload_length)
            && $stable(o_has_byte) && $stable(o_data_byte) && $stable(o_last))
        else $error("stalled result changed");

    // An empty packet result is always the last one and carries a zero byte.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_byte |-> o_last && (o_data_byte == 8'd0)
            && (o_payload_length == 16'd0))
        else $error("empty result malformed");

    // The input is only stalled by a full, stalled output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind length_prefixed_packet_deframer_top lppd_checker u_lppd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_node_id        (o_node_id),
    .o_msg_type       (o_msg_type),
    .o_payload_length (o_payload_length),
    .o_has_byte       (o_has_byte),
    .o_data_byte      (o_data_byte),
    .o_last           (o_last)
);
